[rtl/core/pic_pkg.sv]
`default_nettype none

package pic_pkg;

    // Command codes carried on the cmd field.
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    // Fixed field widths of the item interface.
    localparam int LEN_WIDTH    = 3;
    localparam int FIELD_WIDTH  = 32;
    localparam int INPUT_IDS    = 4;

    // Lookup outcome passed from the entry array to the result register.
    typedef struct packed {
        logic                   hit;
        logic [FIELD_WIDTH-1:0] handle;
    } t_match;

endpackage

`default_nettype wire

[rtl/core/pic_entry_array.sv]
`default_nettype none

module pic_entry_array #(
    parameter int WAYS      = 4,
    parameter int MAX_ARITY = 4,
    parameter int ID_WIDTH  = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_we,
    input  wire logic [pic_pkg::LEN_WIDTH-1:0]       i_len,
    input  wire logic [MAX_ARITY*ID_WIDTH-1:0]       i_tuple,
    input  wire logic [pic_pkg::FIELD_WIDTH-1:0]     i_gen,
    input  wire logic [pic_pkg::FIELD_WIDTH-1:0]     i_handle,
    output pic_pkg::t_match                          o_match
);
    import pic_pkg::*;

    localparam int CW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [WAYS-1:0]                          r_valid;
    logic [LEN_WIDTH-1:0]                     r_len    [WAYS];
    logic [MAX_ARITY*ID_WIDTH-1:0]            r_tuple  [WAYS];
    logic [FIELD_WIDTH-1:0]                   r_gen    [WAYS];
    logic [FIELD_WIDTH-1:0]                   r_handle [WAYS];
    logic [CW-1:0]                            r_cursor;
    logic [CW-1:0]                            n_cursor;
    logic [WAYS-1:0]                          way_hit;

    // Round-robin replacement cursor.
    always_comb begin
        if (r_cursor == CW'(WAYS - 1)) begin
            n_cursor = '0;
        end else begin
            n_cursor = r_cursor + CW'(1);
        end
    end

    // Valid marks and cursor are control state and are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_cursor <= '0;
        end else if (i_we) begin
            r_valid[r_cursor] <= 1'b1;
            r_cursor          <= n_cursor;
        end
    end

    // Entry payload is only read once its valid mark is set.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_len[r_cursor]    <= i_len;
            r_tuple[r_cursor]  <= i_tuple;
            r_gen[r_cursor]    <= i_gen;
            r_handle[r_cursor] <= i_handle;
        end
    end

    // Per-way compare: length, generation and the first len identifiers.
    always_comb begin
        logic cls_ok;
        for (int w = 0; w < WAYS; w++) begin
            cls_ok = 1'b1;
            for (int j = 0; j < MAX_ARITY; j++) begin
                if ((j < int'(i_len)) &&
                    (r_tuple[w][j*ID_WIDTH +: ID_WIDTH] != i_tuple[j*ID_WIDTH +: ID_WIDTH])) begin
                    cls_ok = 1'b0;
                end
            end
            way_hit[w] = r_valid[w] && (r_gen[w] == i_gen) && (r_len[w] == i_len) && cls_ok;
        end
    end

    // The lowest-numbered matching way answers; a miss returns zero.
    always_comb begin
        o_match = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (way_hit[w]) begin
                o_match.hit    = 1'b1;
                o_match.handle = r_handle[w];
            end
        end
    end

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cursor) < WAYS)
        else $error("replacement cursor out of range");

    a_store_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_we |=> r_valid[$past(r_cursor)])
        else $error("stored entry not marked valid");

    a_hit_is_valid_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_match.hit |-> (way_hit & r_valid) != '0)
        else $error("hit reported without a valid matching way");

endmodule

`default_nettype wire

[rtl/core/polymorphic_inline_cache.sv]
`default_nettype none

// Polymorphic inline cache: a fully associative dispatch cache of WAYS
// entries with round-robin replacement. A lookup word returns one result word
// (hit and cached handle, or a miss with a zero handle); a store word writes
// the entry at the replacement cursor and returns nothing. The block takes one
// word per cycle while o_stall is low. A lookup word waits in the input register
// while all ways are compared in parallel, and the outcome is loaded into the
// result register when the result slot can take it. The input stalls only
// while a lookup sits in the input register behind a result word that the
// receiver is holding off; a store in the input register never waits. A lookup
// sees every store accepted before it. All entries are invalid after reset.
module polymorphic_inline_cache #(
    parameter int WAYS      = 4,
    parameter int MAX_ARITY = 4,
    parameter int ID_WIDTH  = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output      logic                                o_stall,
    input  wire logic                                i_cmd,
    input  wire logic [pic_pkg::LEN_WIDTH-1:0]       i_key_len,
    input  wire logic [pic_pkg::FIELD_WIDTH-1:0]     i_class_a,
    input  wire logic [pic_pkg::FIELD_WIDTH-1:0]     i_class_b,
    input  wire logic [pic_pkg::FIELD_WIDTH-1:0]     i_class_c,
    input  wire logic [pic_pkg::FIELD_WIDTH-1:0]     i_class_d,
    input  wire logic [pic_pkg::FIELD_WIDTH-1:0]     i_gen_stamp,
    input  wire logic [pic_pkg::FIELD_WIDTH-1:0]     i_chain_handle,
    output      logic                                o_valid,
    input  wire logic                                i_stall,
    output      logic                                o_hit,
    output      logic [pic_pkg::FIELD_WIDTH-1:0]     o_found_handle
);
    import pic_pkg::*;

    logic [FIELD_WIDTH-1:0]          in_ids [INPUT_IDS];
    logic [MAX_ARITY*ID_WIDTH-1:0]   in_tuple;
    logic [LEN_WIDTH-1:0]            in_len;

    logic                            r_s1_valid;
    logic                            r_s1_cmd;
    logic [LEN_WIDTH-1:0]            r_s1_len;
    logic [MAX_ARITY*ID_WIDTH-1:0]   r_s1_tuple;
    logic [FIELD_WIDTH-1:0]          r_s1_gen;
    logic [FIELD_WIDTH-1:0]          r_s1_handle;

    logic                            r_out_valid;
    logic                            r_out_hit;
    logic [FIELD_WIDTH-1:0]          r_out_handle;

    logic                            out_busy;
    logic                            s1_lookup;
    logic                            s1_advance;
    logic                            in_accept;
    t_match                          match;

    // Tuple gathering: identifiers are resized to ID_WIDTH, missing positions are zero.
    assign in_ids[0] = i_class_a;
    assign in_ids[1] = i_class_b;
    assign in_ids[2] = i_class_c;
    assign in_ids[3] = i_class_d;

    for (genvar j = 0; j < MAX_ARITY; j++) begin : g_tuple
        if (j < INPUT_IDS) begin : g_field
            assign in_tuple[j*ID_WIDTH +: ID_WIDTH] = ID_WIDTH'(in_ids[j]);
        end else begin : g_zero
            assign in_tuple[j*ID_WIDTH +: ID_WIDTH] = '0;
        end
    end

    // Lengths beyond the tuple size saturate.
    assign in_len = (int'(i_key_len) > MAX_ARITY) ? LEN_WIDTH'(MAX_ARITY) : i_key_len;

    // Flow control: a store leaves the input register freely, a lookup needs the result slot.
    assign out_busy   = r_out_valid && i_stall;
    assign s1_lookup  = r_s1_valid && (r_s1_cmd == CMD_LOOKUP);
    assign s1_advance = r_s1_valid && !(s1_lookup && out_busy);
    assign o_stall    = s1_lookup && out_busy;
    assign in_accept  = i_valid && !o_stall;

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd    <= i_cmd;
            r_s1_len    <= in_len;
            r_s1_tuple  <= in_tuple;
            r_s1_gen    <= i_gen_stamp;
            r_s1_handle <= i_chain_handle;
        end
    end

    pic_entry_array #(
        .WAYS      (WAYS),
        .MAX_ARITY (MAX_ARITY),
        .ID_WIDTH  (ID_WIDTH)
    ) u_entries (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (s1_advance && (r_s1_cmd == CMD_STORE)),
        .i_len    (r_s1_len),
        .i_tuple  (r_s1_tuple),
        .i_gen    (r_s1_gen),
        .i_handle (r_s1_handle),
        .o_match  (match)
    );

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_busy) begin
            r_out_valid <= s1_lookup;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (s1_lookup && !out_busy) begin
            r_out_hit    <= match.hit;
            r_out_handle <= match.handle;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_found_handle = r_out_handle;

    a_miss_zero_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_hit |-> r_out_handle == '0)
        else $error("miss result carries a nonzero handle");

    a_stall_only_for_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid && (r_s1_cmd == CMD_LOOKUP) && r_out_valid)
        else $error("input stalled without a blocked lookup");

    a_lookup_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_lookup && !out_busy |=> r_out_valid)
        else $error("lookup dropped before the result register");

    a_store_gives_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_lookup && !out_busy |=> !r_out_valid)
        else $error("result produced without a lookup");

endmodule

`default_nettype wire
